// ----- rtl/bbtl_pkg.sv -----
// Shared types and constants of the blue blob tile locator.
package bbtl_pkg;

  // Payload widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned THR_W      = 20;
  localparam int unsigned LINE_W     = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Largest frame height in lines
  localparam int unsigned MAX_HEIGHT = 2048;

  // Register reset values
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
  localparam logic [THR_W-1:0] DEFICIT_THR_RST  = THR_W'(8192);
  localparam logic [THR_W-1:0] INTENS_MIN_RST   = THR_W'(16384);
  localparam logic [THR_W-1:0] INTENS_MAX_RST   = THR_W'(180000);

  // Full-scale channel value
  localparam logic [PIX_W-1:0] CHAN_MAX = PIX_W'(255);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_DEFICIT_THR  = 3'd2,
    REG_INTENS_MIN   = 3'd3,
    REG_INTENS_MAX   = 3'd4
  } cfg_reg_e;

  // One result item
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } result_t;

endpackage

// ----- rtl/bbtl_if.sv -----
// Valid/ready channel interfaces: pixel input, result output, register writes.
interface bbtl_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bbtl_pkg::PIX_W-1:0] red;
  logic [bbtl_pkg::PIX_W-1:0] green;
  logic [bbtl_pkg::PIX_W-1:0] blue;
  logic                      frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface bbtl_res_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [bbtl_pkg::POS_W-1:0] pos_x;
  logic [bbtl_pkg::POS_W-1:0] pos_y;

  modport source (output valid, found, pos_x, pos_y, input ready);
  modport sink   (input valid, found, pos_x, pos_y, output ready);
endinterface

interface bbtl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbtl_pkg::CFG_IDX_W-1:0]  index;
  logic [bbtl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/blue_blob_tile_locator_top.sv -----
// Top level of the blue blob tile locator.
// Takes one RGB pixel per clock in raster order and sums the blue deficit
// (255 - blue) and the intensity (r + g + b) over non-overlapping tiles of
// TILE_W x TILE_H pixels. The qualifying tile with the smallest deficit is
// tracked (ties go to smaller x, then smaller y), and one result request
// (found, pos_x, pos_y) enters the output buffer at the last pixel of each
// frame. Throughput is one pixel per cycle unless stalled: each pixel passes a
// single add/compare stage, and partial tile sums live in a one-entry-per-tile-
// column memory that is read one pixel ahead of use, so it never stalls the
// stream. Results go through a two-entry output buffer; the pixel input only
// stalls when both entries are held by the result sink. The sums memory needs
// no clearing after reset, because every tile is cleared at its first pixel.
// Register writes take effect immediately and are always accepted.
module blue_blob_tile_locator_top #(
  parameter int unsigned TILE_W    = 16,
  parameter int unsigned TILE_H    = 16,
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbtl_pix_if.sink    pix_i,
  bbtl_res_if.source  res_o,
  bbtl_cfg_if.sink    cfg_i
);
  import bbtl_pkg::*;

  // Derived sizes
  localparam int unsigned TILE_COLS = MAX_WIDTH / TILE_W;
  localparam int unsigned AW        = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int unsigned TXW       = $clog2(TILE_COLS + 1);
  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned WW        = CW + 1;
  localparam int unsigned DXW       = $clog2(TILE_W);
  localparam int unsigned DYW       = $clog2(TILE_H);
  localparam int unsigned DEF_W     = $clog2(255 * TILE_W * TILE_H + 1);
  localparam int unsigned INT_W     = $clog2(765 * TILE_W * TILE_H + 1);
  localparam int unsigned CMP_W     = (INT_W > THR_W) ? INT_W : THR_W;
  localparam int unsigned MEM_W     = DEF_W + INT_W;

  // Configuration registers
  logic [DIM_W-1:0] fw_q, fh_q;
  logic [THR_W-1:0] thr_q, imin_q, imax_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FRAME_WIDTH_RST;
      fh_q   <= FRAME_HEIGHT_RST;
      thr_q  <= DEFICIT_THR_RST;
      imin_q <= INTENS_MIN_RST;
      imax_q <= INTENS_MAX_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH:  fw_q   <= cfg_i.data[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_q   <= cfg_i.data[DIM_W-1:0];
        REG_DEFICIT_THR:  thr_q  <= cfg_i.data[THR_W-1:0];
        REG_INTENS_MIN:   imin_q <= cfg_i.data[THR_W-1:0];
        REG_INTENS_MAX:   imax_q <= cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame geometry
  logic [WW-1:0]    w_eff;
  logic [DIM_W-1:0] h_eff;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if ({1'b0, fw_q} > 13'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (fh_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
  end

  // Position counters: column, offset in tile, tile index, tile origin
  logic [CW-1:0]     col_q, col_d;
  logic [DXW-1:0]    dx_q, dx_d;
  logic [TXW-1:0]    tx_q, tx_d;
  logic [CW-1:0]     ox_q, ox_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [DYW-1:0]    dy_q, dy_d;
  logic [LINE_W-1:0] oy_q, oy_d;

  // Best tile so far
  logic [THR_W-1:0]  best_def_q, best_def_d;
  logic [CW-1:0]     best_x_q, best_x_d;
  logic [LINE_W-1:0] best_y_q, best_y_d;
  logic              best_vld_q, best_vld_d;

  // Running sums of the current tile, including its earlier lines
  logic [DEF_W-1:0] def_acc_q, def_acc_d;
  logic [INT_W-1:0] int_acc_q, int_acc_d;

  // Tile sums memory, read one pixel ahead
  logic [MEM_W-1:0] sum_mem [TILE_COLS];
  logic [DEF_W-1:0] rd_def_q;
  logic [INT_W-1:0] rd_int_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;

  // Output buffer: presented entry and skid entry
  result_t out_q, skid_q, res_new;
  logic    out_vld_q, skid_vld_q;
  logic    accept, frame_end, push, pop;

  assign accept      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = !skid_vld_q;

  // Per-pixel datapath: position, tile sums, best tile and counter advance
  always_comb begin
    logic [CW-1:0]     c;
    logic [DXW-1:0]    dx;
    logic [TXW-1:0]    tx;
    logic [CW-1:0]     ox;
    logic [LINE_W-1:0] l;
    logic [DYW-1:0]    dy;
    logic [LINE_W-1:0] oy;
    logic [THR_W-1:0]  bdef;
    logic [CW-1:0]     bx;
    logic [LINE_W-1:0] by;
    logic              bvld;
    logic              used, last_col, last_row, line_end, better, qual;
    logic [DEF_W-1:0]  def_base, def_sum;
    logic [INT_W-1:0]  int_base, int_sum;
    logic [PIX_W-1:0]  px_def;
    logic [9:0]        px_int;

    // A frame start pixel is taken as pixel (0,0) of a fresh frame
    if (pix_i.frame_start) begin
      c = '0; dx = '0; tx = '0; ox = '0;
      l = '0; dy = '0; oy = '0;
      bdef = thr_q; bx = '0; by = '0; bvld = 1'b0;
    end else begin
      c = col_q; dx = dx_q; tx = tx_q; ox = ox_q;
      l = line_q; dy = dy_q; oy = oy_q;
      bdef = best_def_q; bx = best_x_q; by = best_y_q; bvld = best_vld_q;
    end

    used = (w_eff > WW'(TILE_W)) && (h_eff > DIM_W'(TILE_H))
        && (WW'(ox) < w_eff - WW'(TILE_W))
        && (DIM_W'(oy) < h_eff - DIM_W'(TILE_H))
        && (tx < TXW'(TILE_COLS));
    last_col = (dx == DXW'(TILE_W - 1));
    last_row = (dy == DYW'(TILE_H - 1));

    // Accumulate; a tile starts from zero on its top line, else from memory
    px_def = CHAN_MAX - pix_i.blue;
    px_int = 10'(pix_i.red) + 10'(pix_i.green) + 10'(pix_i.blue);
    if (dx != '0) begin
      def_base = def_acc_q;
      int_base = int_acc_q;
    end else if (dy == '0) begin
      def_base = '0;
      int_base = '0;
    end else begin
      def_base = rd_def_q;
      int_base = rd_int_q;
    end
    def_sum = def_base + DEF_W'(px_def);
    int_sum = int_base + INT_W'(px_int);

    def_acc_d = used ? def_sum : def_acc_q;
    int_acc_d = used ? int_sum : int_acc_q;
    mem_we    = accept && used && last_col;
    mem_waddr = AW'(tx);

    // Tile complete: check and keep the best
    better = (THR_W'(def_sum) < bdef)
          || (bvld && THR_W'(def_sum) == bdef && ox < bx);
    qual   = used && last_col && last_row && better
          && (THR_W'(def_sum) < thr_q)
          && (CMP_W'(int_sum) > CMP_W'(imin_q))
          && (CMP_W'(int_sum) < CMP_W'(imax_q));
    if (qual) begin
      bdef = THR_W'(def_sum);
      bx   = ox;
      by   = oy;
      bvld = 1'b1;
    end

    // Result of a finished frame
    res_new.found = bvld;
    res_new.pos_x = bvld ? POS_W'(bx) : '0;
    res_new.pos_y = bvld ? POS_W'(by) : '0;

    line_end  = (WW'(c) + WW'(1)) >= w_eff;
    frame_end = line_end && ((DIM_W'(l) + DIM_W'(1)) >= h_eff);

    // Counter advance
    best_def_d = bdef; best_x_d = bx; best_y_d = by; best_vld_d = bvld;
    col_d = c; dx_d = dx; tx_d = tx; ox_d = ox;
    line_d = l; dy_d = dy; oy_d = oy;
    if (frame_end) begin
      col_d = '0; dx_d = '0; tx_d = '0; ox_d = '0;
      line_d = '0; dy_d = '0; oy_d = '0;
      best_def_d = thr_q; best_x_d = '0; best_y_d = '0; best_vld_d = 1'b0;
    end else if (line_end) begin
      col_d = '0; dx_d = '0; tx_d = '0; ox_d = '0;
      line_d = l + LINE_W'(1);
      if (last_row) begin
        dy_d = '0;
        oy_d = oy + LINE_W'(TILE_H);
      end else begin
        dy_d = dy + DYW'(1);
      end
    end else begin
      col_d = c + CW'(1);
      if (last_col) begin
        dx_d = '0;
        tx_d = tx + TXW'(1);
        ox_d = CW'(WW'(ox) + WW'(TILE_W));
      end else begin
        dx_d = dx + DXW'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      dx_q       <= '0;
      tx_q       <= '0;
      ox_q       <= '0;
      line_q     <= '0;
      dy_q       <= '0;
      oy_q       <= '0;
      best_def_q <= DEFICIT_THR_RST;
      best_x_q   <= '0;
      best_y_q   <= '0;
      best_vld_q <= 1'b0;
    end else if (accept) begin
      col_q      <= col_d;
      dx_q       <= dx_d;
      tx_q       <= tx_d;
      ox_q       <= ox_d;
      line_q     <= line_d;
      dy_q       <= dy_d;
      oy_q       <= oy_d;
      best_def_q <= best_def_d;
      best_x_q   <= best_x_d;
      best_y_q   <= best_y_d;
      best_vld_q <= best_vld_d;
    end
  end

  // Tile accumulators
  always_ff @(posedge clk_i) begin
    if (accept) begin
      def_acc_q <= def_acc_d;
      int_acc_q <= int_acc_d;
    end
  end

  // Sums memory: write at a tile's last column, read the tile the next pixel sits in
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= {def_acc_d, int_acc_d};
    end
    {rd_def_q, rd_int_q} <= sum_mem[AW'(accept ? tx_d : tx_q)];
  end

  // Output buffer
  assign push = accept && frame_end;
  assign pop  = out_vld_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= push;
      end else begin
        out_vld_q  <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res_new;
        end
      end else if (push) begin
        out_q <= res_new;
      end
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.found = out_q.found;
  assign res_o.pos_x = out_q.pos_x;
  assign res_o.pos_y = out_q.pos_y;

endmodule
